// ===== rtl/core/dptg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dptg_pkg
// Shared widths, constants and register indexes of the DDS phase/table block.
// ----------------------------------------------------------------------------
package dptg_pkg;

  // Waveform table depth; a power of two in 256..65536.
  localparam int TABLE_LEN = 4096;
  localparam int TBL_AW    = $clog2(TABLE_LEN);

  localparam int PHASE_W   = 32;
  localparam int CODE_W    = 12;
  localparam int FADDR_W   = 12;   // width of the table_addr field
  localparam int CFG_W     = 32;   // widest configuration register
  localparam int CFG_IDX_W = 1;

  localparam logic [CODE_W-1:0] MID_CODE = CODE_W'(2048);

  // Request kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 1'b1;

endpackage

// ===== rtl/core/dptg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dptg_in_if / dptg_out_if
// Valid/ready channels for requests into and samples out of the DDS block.
// ----------------------------------------------------------------------------
interface dptg_in_if;
  import dptg_pkg::*;

  logic               valid;
  logic               ready;
  logic               kind;
  logic [FADDR_W-1:0] table_addr;
  logic [CODE_W-1:0]  table_data;

  modport source (output valid, output kind, output table_addr, output table_data,
                  input ready);
  modport sink   (input valid, input kind, input table_addr, input table_data,
                  output ready);
endinterface

interface dptg_out_if;
  import dptg_pkg::*;

  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] sample_code;

  modport source (output valid, output sample_code, input ready);
  modport sink   (input valid, input sample_code, output ready);
endinterface

// ===== rtl/core/dptg_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dptg_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dptg_ram #(
  parameter int DATA_W = 12,
  parameter int DEPTH  = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/dds_phase_table_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_phase_table_generator
// Direct digital synthesizer: 32-bit phase accumulator over a loadable table.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while in_req.ready is high and
// returns one sample per tick request, which passes through the registered
// read of the waveform table RAM and then the output register; a stalled
// output holds both. The table RAM has separate write and read ports.
// Table-write requests (kind = 1) store table_data at table_addr and produce
// no sample. Tick requests (kind = 0) emit the table entry indexed by the top
// bits of the phase and then advance the phase by phase_step; while disabled
// or with a zero step they emit mid-scale 2048 and clear the phase. Writing 1
// to the enable register also clears the phase. Load every table entry the
// phase can reach before enabling: an unwritten entry reads back as an
// unknown code. The table RAM has no clearing pass and is usable right after
// reset.
// ----------------------------------------------------------------------------
module dds_phase_table_generator
  import dptg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,

  dptg_in_if.sink              in_req,
  dptg_out_if.source           out_res
);

  // Configuration registers
  logic               enable_r;
  logic [PHASE_W-1:0] phase_step_r;

  // Phase accumulator
  logic [PHASE_W-1:0] phase_r;
  logic [PHASE_W-1:0] phase_nxt;

  // Read stage: RAM data is valid while s1_valid_r is high and s1_mid_r is low
  logic               s1_valid_r;
  logic               s1_mid_r;

  // Output register
  logic               out_valid_r;
  logic [CODE_W-1:0]  out_code_r;

  logic               in_fire;
  logic               tick_fire;
  logic               wr_fire;
  logic               run;
  logic               s1_advance;
  logic               wr_in_range;
  logic [CODE_W-1:0]  ram_rdata;

  // Advance the read stage whenever the output register is free or drains.
  assign s1_advance   = !out_valid_r || out_res.ready;
  assign in_req.ready = !s1_valid_r || s1_advance;

  assign in_fire   = in_req.valid && in_req.ready;
  assign tick_fire = in_fire && (in_req.kind == KIND_TICK);
  assign wr_fire   = in_fire && (in_req.kind == KIND_WRITE);

  assign run = enable_r && (phase_step_r != '0);

  // Drop writes beyond the table depth.
  assign wr_in_range = (32'(in_req.table_addr) < 32'(TABLE_LEN));

  // Waveform table: written by write requests, read by running ticks.
  dptg_ram #(
    .DATA_W (CODE_W),
    .DEPTH  (TABLE_LEN)
  ) u_table (
    .clk   (clk),
    .we    (wr_fire && wr_in_range),
    .waddr (TBL_AW'(in_req.table_addr)),
    .wdata (in_req.table_data),
    .re    (tick_fire && run),
    .raddr (phase_r[PHASE_W-1 -: TBL_AW]),
    .rdata (ram_rdata)
  );

  // Phase update: clear on an idle tick or on enabling, advance on a run tick.
  always_comb begin
    phase_nxt = phase_r;
    if (cfg_we && (cfg_index == CFG_ENABLE) && cfg_wdata[0]) begin
      phase_nxt = '0;
    end else if (tick_fire) begin
      if (run) begin
        phase_nxt = phase_r + phase_step_r;
      end else begin
        phase_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      phase_step_r <= '0;
      phase_r      <= '0;
    end else begin
      phase_r <= phase_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE:     enable_r     <= cfg_wdata[0];
          CFG_PHASE_STEP: phase_step_r <= cfg_wdata[PHASE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Read stage control; hold while the output register is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      s1_valid_r <= tick_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      s1_mid_r <= !run;
    end
  end

  // Output register: take the read stage when free or draining.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid_r) begin
      out_code_r <= s1_mid_r ? MID_CODE : ram_rdata;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.sample_code = out_code_r;

endmodule
